/* design/apc_pkg.sv */
// Shared types and constants for the angle PID controller.
// No dependencies; every other file imports this package.
package apc_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int OUT_FULL_SCALE_DEF = 128;

  localparam int ERR_W       = 9;
  localparam int GAIN_W      = 16;
  localparam int MAX_SPEED_W = 12;
  localparam int DRIVE_W     = 13;
  localparam int SUM_W       = 18;
  localparam int MUL_B_W     = GAIN_W + 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int DEG_HALF    = 180;
  localparam int DEG_FULL    = 360;
  localparam int BLEND_NEW   = 179;
  localparam int BLEND_OLD   = 77;
  localparam int BLEND_SHIFT = 8;

  localparam logic [GAIN_W-1:0]      PROP_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]      INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0]      DERIV_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0]      STEP_LIM_RST   = 16'hFFFF;
  localparam logic [GAIN_W-1:0]      SAT_LIM_RST    = 16'hFFFF;
  localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST  = 12'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_STEP_LIM   = 3'd3,
    CFG_SAT_LIM    = 3'd4,
    CFG_MAX_SPEED  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]      prop_gain;
    logic [GAIN_W-1:0]      integ_gain;
    logic [GAIN_W-1:0]      deriv_gain;
    logic [GAIN_W-1:0]      integ_step_limit;
    logic [GAIN_W-1:0]      integ_saturation;
    logic [MAX_SPEED_W-1:0] max_speed;
  } apc_cfg_t;

endpackage

/* design/apc_if.sv */
// Valid/ready channel interfaces for request and result words.
// Depends on apc_pkg for field widths.
interface apc_req_if import apc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [ERR_W-1:0] error_in;

  modport source (output valid, output req_type, output error_in, input ready);
  modport sink (input valid, input req_type, input error_in, output ready);
endinterface

interface apc_res_if import apc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      out_clamped;

  modport source (output valid, output drive, output out_clamped, input ready);
  modport sink (input valid, input drive, input out_clamped, output ready);
endinterface

/* design/angle_pid_controller_top.sv */
// Angle PID controller top level: sequencer around one shared multiplier.
// Depends on apc_pkg, apc_if, apc_cfg_regs and apc_mul_unit.
//
//   channel | direction | handshake     | payload
//   in_ch   | sink      | valid/ready   | req_type, error_in
//   out_ch  | source    | valid/ready   | drive, out_clamped
//   cfg_*   | write     | cfg_we strobe | cfg_addr, cfg_wdata
//
// A run word goes from acceptance to the next ready through the accepting cycle,
// ten multiply and combine steps through the shared multiplier, three steps for the
// full-scale scaling (reciprocal multiply, quotient check, one-step fixup), and a
// final step to post. A clear word is done in its accepting cycle and posts nothing.
// Reset is synchronous; it clears controller state and restores register defaults.
// A result not taken holds the sequencer in its final step; the output register
// lets the next word in as soon as the previous result has been posted.
module angle_pid_controller_top import apc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int OUT_FULL_SCALE = OUT_FULL_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  apc_req_if.sink               in_ch,
  apc_res_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LIM_SHIFT = GAIN_FRAC_BITS + 8;
  localparam int LIM_BITS  = $clog2(OUT_FULL_SCALE + 1) + LIM_SHIFT;
  localparam int RAW_W     = (LIM_BITS + 2 > 35) ? LIM_BITS + 2 : 35;
  localparam int P_W       = RAW_W + MUL_B_W;
  localparam int PT_W      = ERR_W + MUL_B_W;
  localparam int BL_W      = SUM_W;
  localparam int Q_W       = MAX_SPEED_W;
  localparam int T_W       = $clog2(OUT_FULL_SCALE) + Q_W + 1;
  localparam int RCP_SHIFT = 15 + $clog2(OUT_FULL_SCALE + 1) - 1;

  localparam logic [RAW_W-1:0]  LIM      = RAW_W'(OUT_FULL_SCALE) << LIM_SHIFT;
  localparam logic [P_W-1:0]    HALF_LIM = P_W'(LIM) >> 1;
  localparam logic [GAIN_W-1:0] RCP_MUL  =
    GAIN_W'((longint'(1) << RCP_SHIFT) / OUT_FULL_SCALE);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_PROP  = 15'b000000000000010,
    ST_DMUL  = 15'b000000000000100,
    ST_PMUL  = 15'b000000000001000,
    ST_IMUL  = 15'b000000000010000,
    ST_KDMUL = 15'b000000000100000,
    ST_INTEG = 15'b000000001000000,
    ST_RAW   = 15'b000000010000000,
    ST_CLAMP = 15'b000000100000000,
    ST_SCALE = 15'b000001000000000,
    ST_ROUND = 15'b000010000000000,
    ST_RECIP = 15'b000100000000000,
    ST_QMUL  = 15'b001000000000000,
    ST_FIX   = 15'b010000000000000,
    ST_OUT   = 15'b100000000000000
  } state_t;

  apc_cfg_t cfg;

  state_t state_r, state_nxt;

  logic signed [ERR_W-1:0]   e_r, e_nxt;
  logic signed [ERR_W-1:0]   d_r, d_nxt;
  logic signed [PT_W-1:0]    pterm_r, pterm_nxt;
  logic signed [BL_W-1:0]    blend_r, blend_nxt;
  logic signed [SUM_W-1:0]   istep_r, istep_nxt;
  logic signed [SUM_W-1:0]   integ_r, integ_nxt;
  logic signed [RAW_W-1:0]   dterm_r, dterm_nxt;
  logic signed [RAW_W-1:0]   raw_r, raw_nxt;
  logic [RAW_W-1:0]          mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic                      clamped_r, clamped_nxt;
  logic [T_W-1:0]            rem_r, rem_nxt;
  logic [Q_W-1:0]            quo_r, quo_nxt;

  logic signed [ERR_W-1:0]   last_r, last_nxt;
  logic signed [ERR_W-1:0]   prev_r, prev_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;

  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic                      oclamp_r, oclamp_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic signed [RAW_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]     prod;

  logic signed [ERR_W:0]     diff, fold;
  logic signed [PT_W-1:0]    iprod, step_lim;
  logic signed [SUM_W:0]     isum, sat_lim;
  logic [RAW_W-1:0]          raw_abs;
  logic [P_W-1:0]            rnd;
  logic [Q_W-1:0]            qest;
  logic [T_W-1:0]            rdiff;
  logic                      fix_up;
  logic [BL_W-1:0]           blend_abs;
  logic signed [ERR_W-1:0]   bmag;
  logic signed [DRIVE_W-1:0] qext;
  logic                      slot_free;
  logic                      in_acc;

  apc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  apc_mul_unit #(.A_W(RAW_W)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign slot_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive       = drive_r;
  assign out_ch.out_clamped = oclamp_r;

  // wrapped difference, folded once
  always_comb begin
    diff = (ERR_W+1)'(e_r) - (ERR_W+1)'(last_r);
    if (diff > $signed((ERR_W+1)'(DEG_HALF))) begin
      fold = diff - $signed((ERR_W+1)'(DEG_FULL));
    end else if (diff < -$signed((ERR_W+1)'(DEG_HALF))) begin
      fold = diff + $signed((ERR_W+1)'(DEG_FULL));
    end else begin
      fold = diff;
    end
  end

  always_comb begin
    iprod    = prod[PT_W-1:0];
    step_lim = $signed(PT_W'(cfg.integ_step_limit));
    isum     = (SUM_W+1)'(istep_r) + (SUM_W+1)'(sum_r);
    sat_lim  = $signed((SUM_W+1)'(cfg.integ_saturation));
    raw_abs  = raw_r[RAW_W-1] ? $unsigned(-raw_r) : $unsigned(raw_r);
    rnd      = $unsigned(prod) + HALF_LIM;
    qest     = Q_W'(prod >> RCP_SHIFT);
    rdiff    = rem_r - T_W'(prod);
    fix_up   = (rdiff >= T_W'(OUT_FULL_SCALE));
    blend_abs = blend_r[BL_W-1] ? $unsigned(-blend_r) : $unsigned(blend_r);
    bmag     = $signed(ERR_W'(blend_abs >> BLEND_SHIFT));
    qext     = $signed({1'b0, quo_r});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_PROP: begin
        mul_a = RAW_W'(e_r);
        mul_b = $signed({1'b0, cfg.prop_gain});
      end
      ST_DMUL: begin
        mul_a = RAW_W'(d_r);
        mul_b = MUL_B_W'(BLEND_NEW);
      end
      ST_PMUL: begin
        mul_a = RAW_W'(prev_r);
        mul_b = MUL_B_W'(BLEND_OLD);
      end
      ST_IMUL: begin
        mul_a = RAW_W'(e_r);
        mul_b = $signed({1'b0, cfg.integ_gain});
      end
      ST_KDMUL: begin
        mul_a = RAW_W'(blend_r);
        mul_b = $signed({1'b0, cfg.deriv_gain});
      end
      ST_SCALE: begin
        mul_a = $signed(mag_r);
        mul_b = $signed(MUL_B_W'(cfg.max_speed));
      end
      ST_RECIP: begin
        mul_a = RAW_W'(rem_r);
        mul_b = $signed({1'b0, RCP_MUL});
      end
      ST_QMUL: begin
        mul_a = RAW_W'(qest);
        mul_b = MUL_B_W'(OUT_FULL_SCALE);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    d_nxt         = d_r;
    pterm_nxt     = pterm_r;
    blend_nxt     = blend_r;
    istep_nxt     = istep_r;
    integ_nxt     = integ_r;
    dterm_nxt     = dterm_r;
    raw_nxt       = raw_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    clamped_nxt   = clamped_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    drive_nxt     = drive_r;
    oclamp_nxt    = oclamp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type) begin
            last_nxt = '0;
            prev_nxt = '0;
            sum_nxt  = '0;
          end else begin
            e_nxt     = in_ch.error_in;
            state_nxt = ST_PROP;
          end
        end
      end
      ST_PROP: begin
        d_nxt     = ERR_W'(fold);
        state_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        pterm_nxt = prod[PT_W-1:0];
        state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        blend_nxt = prod[BL_W-1:0];
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        blend_nxt = blend_r + prod[BL_W-1:0];
        state_nxt = ST_KDMUL;
      end
      ST_KDMUL: begin
        if (iprod > step_lim) begin
          istep_nxt = SUM_W'(step_lim);
        end else if (iprod < -step_lim) begin
          istep_nxt = SUM_W'(-step_lim);
        end else begin
          istep_nxt = SUM_W'(iprod);
        end
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        dterm_nxt = prod[RAW_W-1:0];
        if (isum > sat_lim) begin
          integ_nxt = SUM_W'(sat_lim);
        end else if (isum < -sat_lim) begin
          integ_nxt = SUM_W'(-sat_lim);
        end else begin
          integ_nxt = SUM_W'(isum);
        end
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        raw_nxt   = ((RAW_W'(pterm_r) + RAW_W'(integ_r)) <<< BLEND_SHIFT) + dterm_r;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        neg_nxt     = raw_r[RAW_W-1];
        clamped_nxt = (raw_abs > LIM);
        mag_nxt     = (raw_abs > LIM) ? LIM : raw_abs;
        state_nxt   = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rem_nxt   = T_W'(rnd >> LIM_SHIFT);
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        state_nxt = ST_QMUL;
      end
      ST_QMUL: begin
        quo_nxt   = qest;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        if (fix_up) begin
          quo_nxt = quo_r + 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          drive_nxt     = neg_r ? -qext : qext;
          oclamp_nxt    = clamped_r;
          out_valid_nxt = 1'b1;
          last_nxt      = e_r;
          prev_nxt      = blend_r[BL_W-1] ? -bmag : bmag;
          sum_nxt       = integ_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      prev_r      <= '0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    d_r       <= d_nxt;
    pterm_r   <= pterm_nxt;
    blend_r   <= blend_nxt;
    istep_r   <= istep_nxt;
    integ_r   <= integ_nxt;
    dterm_r   <= dterm_nxt;
    raw_r     <= raw_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    clamped_r <= clamped_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    drive_r   <= drive_nxt;
    oclamp_r  <= oclamp_nxt;
  end

endmodule

/* design/apc_cfg_regs.sv */
// Configuration register bank: gains, limits and full-scale speed.
// Depends on apc_pkg for the register indexes, reset values and struct.
module apc_cfg_regs import apc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output apc_cfg_t              cfg
);

  apc_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_PROP_GAIN:  cfg_nxt.prop_gain        = cfg_wdata[GAIN_W-1:0];
        CFG_INTEG_GAIN: cfg_nxt.integ_gain       = cfg_wdata[GAIN_W-1:0];
        CFG_DERIV_GAIN: cfg_nxt.deriv_gain       = cfg_wdata[GAIN_W-1:0];
        CFG_STEP_LIM:   cfg_nxt.integ_step_limit = cfg_wdata[GAIN_W-1:0];
        CFG_SAT_LIM:    cfg_nxt.integ_saturation = cfg_wdata[GAIN_W-1:0];
        CFG_MAX_SPEED:  cfg_nxt.max_speed        = cfg_wdata[MAX_SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain        <= PROP_GAIN_RST;
      cfg_r.integ_gain       <= INTEG_GAIN_RST;
      cfg_r.deriv_gain       <= DERIV_GAIN_RST;
      cfg_r.integ_step_limit <= STEP_LIM_RST;
      cfg_r.integ_saturation <= SAT_LIM_RST;
      cfg_r.max_speed        <= MAX_SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/apc_mul_unit.sv */
// Shared signed multiplier with a registered product.
// Depends on apc_pkg for the width of the second operand.
module apc_mul_unit import apc_pkg::*; #(
  parameter int A_W = 35
) (
  input  logic                            clk,
  input  logic signed [A_W-1:0]           op_a,
  input  logic signed [MUL_B_W-1:0]       op_b,
  output logic signed [A_W+MUL_B_W-1:0]   prod
);

  logic signed [A_W+MUL_B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

/* design/apc_checker.sv */
// Port-level checks for the angle PID controller, bound to the top level.
// Depends on apc_pkg for field widths and on angle_pid_controller_top.
module apc_port_checks import apc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_req_type,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] out_drive,
  input logic                      out_clamped
);

  a_reset_drops_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_clamped))
    else $error("stalled result word changed or dropped");

  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type |=> !in_ready)
    else $error("run word accepted but controller not busy");

  a_clear_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=> in_ready)
    else $error("clear word left controller busy");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive word outside symmetric range");

endmodule

bind angle_pid_controller_top apc_port_checks u_apc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_drive   (out_ch.drive),
  .out_clamped (out_ch.out_clamped)
);

/* tb/apc_tb_pkg.sv */
// Request codes and spare register indexes shared by the testbench files.
// Depends on apc_pkg for the register index width.
package apc_tb_pkg;
  import apc_pkg::*;

  localparam logic REQ_RUN   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

endpackage

/* tb/apc_checker.sv */
// Checker for the angle PID controller: watches request, result and register
// writes, predicts every result word and compares it field by field.
// Depends on apc_pkg, apc_tb_pkg and the channel interfaces in apc_if.
module apc_checker import apc_pkg::*, apc_tb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  apc_req_if                    in_mon,
  apc_res_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    clamped_seen
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      out_clamped;
  } drive_word_t;

  localparam longint FULL_SCALE_Q =
    longint'(OUT_FULL_SCALE_DEF) <<< (GAIN_FRAC_BITS_DEF + BLEND_SHIFT);

  apc_cfg_t                regs;
  logic signed [SUM_W-1:0] integ_sum;
  logic signed [ERR_W-1:0] last_err;
  logic signed [ERR_W-1:0] prev_deriv;
  drive_word_t             drive_q[$];
  int                      n_fail = 0;
  int                      n_checked = 0;
  int                      n_clamped = 0;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  always @(posedge clk) begin : track
    longint      e;
    longint      d;
    longint      blend;
    longint      integ;
    longint      raw;
    longint      mag;
    longint      q;
    longint      bmag;
    drive_word_t want;
    drive_word_t got;
    if (!rst_n) begin
      regs.prop_gain        = PROP_GAIN_RST;
      regs.integ_gain       = INTEG_GAIN_RST;
      regs.deriv_gain       = DERIV_GAIN_RST;
      regs.integ_step_limit = STEP_LIM_RST;
      regs.integ_saturation = SAT_LIM_RST;
      regs.max_speed        = MAX_SPEED_RST;
      integ_sum  = '0;
      last_err   = '0;
      prev_deriv = '0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PROP_GAIN:  regs.prop_gain        = cfg_wdata;
          CFG_INTEG_GAIN: regs.integ_gain       = cfg_wdata;
          CFG_DERIV_GAIN: regs.deriv_gain       = cfg_wdata;
          CFG_STEP_LIM:   regs.integ_step_limit = cfg_wdata;
          CFG_SAT_LIM:    regs.integ_saturation = cfg_wdata;
          CFG_MAX_SPEED:  regs.max_speed        = cfg_wdata[MAX_SPEED_W-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        got.drive       = out_mon.drive;
        got.out_clamped = out_mon.out_clamped;
        if (drive_q.size() == 0) begin
          $error("unexpected result word: drive %0d out_clamped %0b",
                 got.drive, got.out_clamped);
          n_fail++;
        end else begin
          want = drive_q.pop_front();
          n_checked++;
          if (got.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, got.drive);
            n_fail++;
          end
          if (got.out_clamped !== want.out_clamped) begin
            $error("out_clamped: expected %0b, got %0b", want.out_clamped, got.out_clamped);
            n_fail++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == REQ_CLEAR) begin
          integ_sum  = '0;
          last_err   = '0;
          prev_deriv = '0;
        end else begin
          e = longint'(in_mon.error_in);
          d = e - longint'(last_err);
          if (d > DEG_HALF) d = d - DEG_FULL;
          else if (d < -DEG_HALF) d = d + DEG_FULL;
          blend = d * BLEND_NEW + longint'(prev_deriv) * BLEND_OLD;

          integ = clamp_sym(e * longint'(regs.integ_gain), longint'(regs.integ_step_limit));
          integ = clamp_sym(integ + longint'(integ_sum), longint'(regs.integ_saturation));

          raw = ((e * longint'(regs.prop_gain) + integ) <<< BLEND_SHIFT)
              + blend * longint'(regs.deriv_gain);
          want.out_clamped = (raw > FULL_SCALE_Q) || (raw < -FULL_SCALE_Q);
          raw = clamp_sym(raw, FULL_SCALE_Q);

          // round half away from zero on the magnitude
          mag = (raw < 0) ? -raw : raw;
          q = (mag * longint'(regs.max_speed) + FULL_SCALE_Q / 2) / FULL_SCALE_Q;
          want.drive = DRIVE_W'((raw < 0) ? -q : q);

          bmag = ((blend < 0) ? -blend : blend) >>> BLEND_SHIFT;
          prev_deriv = ERR_W'((blend < 0) ? -bmag : bmag);
          last_err   = in_mon.error_in;
          integ_sum  = SUM_W'(integ);

          drive_q.push_back(want);
          if (want.out_clamped) n_clamped++;
        end
      end
    end
    fail_count   <= n_fail;
    pending      <= drive_q.size();
    checked      <= n_checked;
    clamped_seen <= n_clamped;
  end

endmodule

/* tb/angle_pid_controller_top_test.sv */
// Testbench top for angle_pid_controller_top: drives request words and register
// writes with random gaps and stalls; apc_checker predicts and compares.
// Depends on apc_pkg, apc_tb_pkg, apc_if, apc_checker and the design.
module angle_pid_controller_top_test;
  import apc_pkg::*;
  import apc_tb_pkg::*;

  localparam int RUN_WORDS     = 1250;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 32;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    quiet = 1'b0;
  int                    n_fail;
  int                    n_pending;
  int                    n_checked;
  int                    n_clamped;
  int                    runs_sent = 0;
  int                    clears_sent = 0;
  int                    settings = 1;
  int                    walk = 0;

  apc_req_if in_if ();
  apc_res_if out_if ();

  angle_pid_controller_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  apc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (n_fail),
    .pending      (n_pending),
    .checked      (n_checked),
    .clamped_seen (n_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("angle_pid_controller_top regression: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int typical_max);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, typical_max));
  endfunction

  // result side: stall at random, hold ready low for the drawn count
  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        hold = gap_len();
      end
    end
  end

  task automatic send_word(input logic rt, input logic signed [ERR_W-1:0] err);
    int gap;
    in_if.valid    <= 1'b1;
    in_if.req_type <= rt;
    in_if.error_in <= err;
    do @(posedge clk); while (!in_if.ready);
    if (rt == REQ_CLEAR) clears_sent++;
    else runs_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, wait for every expected word, then let a clear finish
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] pg, input logic [CFG_DATA_W-1:0] ig,
                          input logic [CFG_DATA_W-1:0] dg, input logic [CFG_DATA_W-1:0] sl,
                          input logic [CFG_DATA_W-1:0] sa, input logic [CFG_DATA_W-1:0] ms);
    cfg_write(CFG_PROP_GAIN, pg);
    cfg_write(CFG_INTEG_GAIN, ig);
    cfg_write(CFG_DERIV_GAIN, dg);
    cfg_write(CFG_STEP_LIM, sl);
    cfg_write(CFG_SAT_LIM, sa);
    cfg_write(CFG_MAX_SPEED, ms);
    cfg_release();
    settings++;
  endtask

  task automatic random_word();
    int r;
    int ev;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_word(REQ_CLEAR, ERR_W'($urandom));
      walk = 0;
    end else begin
      if (r < 70) begin
        walk = walk + $urandom_range(0, 40) - 20;
        if (walk > DEG_HALF) walk = DEG_HALF;
        if (walk < -DEG_HALF) walk = -DEG_HALF;
        ev = walk;
      end else if (r < 90) begin
        ev = $urandom_range(0, 511) - 256;
      end else begin
        case ($urandom_range(0, 4))
          0: ev = -256;
          1: ev = 255;
          2: ev = DEG_HALF;
          3: ev = -DEG_HALF;
          default: ev = 0;
        endcase
      end
      send_word(REQ_RUN, ERR_W'(ev));
    end
  endtask

  initial begin
    int per_phase;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_addr       <= '0;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.req_type <= REQ_RUN;
    in_if.error_in <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: unity proportional, full scale edges, unfolded errors
    send_word(REQ_RUN, ERR_W'(0));
    send_word(REQ_RUN, ERR_W'(128));
    send_word(REQ_RUN, ERR_W'(129));
    send_word(REQ_RUN, ERR_W'(-128));
    send_word(REQ_RUN, ERR_W'(-129));
    send_word(REQ_RUN, ERR_W'(255));
    send_word(REQ_RUN, ERR_W'(-256));
    send_word(REQ_RUN, ERR_W'(180));
    send_word(REQ_RUN, ERR_W'(-180));
    send_word(REQ_CLEAR, ERR_W'(-1));
    send_word(REQ_RUN, ERR_W'(1));
    drain();

    // integral up to saturation; spare indexes and high bits must be ignored
    cfg_write(CFG_SPARE_LO, '1);
    cfg_write(CFG_SPARE_HI, '0);
    set_regs(16'h0040, 16'hFFFF, 16'h0300, 16'h0400, 16'h1000, 16'hFFFF);
    send_word(REQ_RUN, ERR_W'(100));
    send_word(REQ_RUN, ERR_W'(100));
    send_word(REQ_RUN, ERR_W'(100));
    send_word(REQ_RUN, ERR_W'(100));
    send_word(REQ_RUN, ERR_W'(-90));
    send_word(REQ_RUN, ERR_W'(170));
    drain();

    // lower saturation below the held sum
    cfg_write(CFG_SAT_LIM, 16'h0080);
    cfg_release();
    settings++;
    send_word(REQ_RUN, ERR_W'(10));
    send_word(REQ_RUN, ERR_W'(-10));
    drain();

    set_regs('0, '0, '0, '0, '0, '0);
    send_word(REQ_RUN, ERR_W'(255));
    send_word(REQ_RUN, ERR_W'(-256));
    send_word(REQ_CLEAR, ERR_W'(0));

    per_phase = RUN_WORDS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 1) set_regs('1, '1, '1, '1, '1, '1);
      else if (p == 2) set_regs('0, 16'h0100, '0, 16'h0080, 16'h0200, 16'h0800);
      else set_regs(pick_reg(640), pick_reg(96), pick_reg(512), pick_reg(4096),
                    pick_reg(40000), CFG_DATA_W'($urandom));
      for (int i = 0; i < per_phase; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (p == 3 && i == per_phase / 2) drain();
        random_word();
      end
    end
    quiet = 1'b0;
    drain();

    $display("covered %0d run words and %0d clears over %0d register settings",
             runs_sent, clears_sent, settings);
    $display("%0d result words checked, %0d of them clamped at full scale",
             n_checked, n_clamped);
    if (n_fail == 0) begin
      $display("angle_pid_controller_top regression: pass");
    end else begin
      $display("angle_pid_controller_top regression: fail");
    end
    $finish;
  end

endmodule
